// ===== sv/gcm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gcm_pkg
// shared types, codes and widths of the gcm authentication tag engine
// ----------------------------------------------------------------------------
package gcm_pkg;

   localparam int BLOCK_W     = 128;
   localparam int HALF_W      = 64;
   localparam int COUNT_W     = 5;
   localparam int LEN_W       = 61;
   localparam int DIGIT_W     = 32;
   localparam int DIGITS      = BLOCK_W / DIGIT_W;
   localparam int DIGIT_CNT_W = $clog2(DIGITS);
   localparam int BLOCK_BYTES = BLOCK_W / 8;

   localparam int REQ_DATA_W  = 136;
   localparam int RSP_DATA_W  = 136;
   localparam int OP_W        = 2;
   localparam int CSR_IDX_W   = 2;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [7:0] REDUCE_BYTE = 8'he1;

   // request op codes
   localparam logic [OP_W-1:0] OP_AAD    = 2'd0;
   localparam logic [OP_W-1:0] OP_TEXT   = 2'd1;
   localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HI  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LO  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK_HI = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK_LO = 2'd3;

   typedef enum logic [1:0] {
      CMD_AAD,
      CMD_TEXT,
      CMD_FINISH
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type         kind;
      logic [BLOCK_W-1:0]   blk;
      logic [COUNT_W-1:0]   count;
   } cmd_type;

endpackage
`default_nettype wire

// ===== sv/gcm_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gcm_front
// accepts request items, pads short blocks, drops empty or unused items
// ----------------------------------------------------------------------------
module gcm_front (
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [gcm_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  wire logic [gcm_pkg::OP_W-1:0]        req_tuser,
   input  wire logic                            q_full,
   output logic                                 push,
   output gcm_pkg::cmd_type                     cmd
);
   import gcm_pkg::*;

   logic [HALF_W-1:0]  blk_hi;
   logic [HALF_W-1:0]  blk_lo;
   logic [COUNT_W-1:0] raw_count;
   logic [COUNT_W-1:0] count;
   logic [BLOCK_W-1:0] blk;
   logic [BLOCK_W-1:0] padded;
   logic               keep;

   assign blk_hi     = req_tdata[HALF_W-1:0];
   assign blk_lo     = req_tdata[2*HALF_W-1:HALF_W];
   assign raw_count  = req_tdata[2*HALF_W+COUNT_W-1:2*HALF_W];
   assign blk        = {blk_hi, blk_lo};
   assign req_tready = !q_full;

   always_comb begin
      count = (raw_count > COUNT_W'(BLOCK_BYTES)) ? COUNT_W'(BLOCK_BYTES) : raw_count;
      // keep leading bytes, byte 0 in the top bits
      for (int b = 0; b < BLOCK_BYTES; b++) begin
         padded[BLOCK_W-1-8*b -: 8] = (b < int'(count)) ? blk[BLOCK_W-1-8*b -: 8] : 8'h00;
      end
      cmd.count = count;
      cmd.blk   = padded;
      cmd.kind  = CMD_AAD;
      keep      = 1'b0;
      case (req_tuser)
         OP_AAD: begin
            cmd.kind = CMD_AAD;
            keep     = (raw_count != '0);
         end
         OP_TEXT: begin
            cmd.kind = CMD_TEXT;
            keep     = (raw_count != '0);
         end
         OP_FINISH: begin
            cmd.kind = CMD_FINISH;
            cmd.blk  = blk;
            keep     = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign push = req_tvalid && !q_full && keep;

endmodule
`default_nettype wire

// ===== sv/gcm_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gcm_queue
// small command queue between the front and the hash datapath
// ----------------------------------------------------------------------------
module gcm_queue #(
   parameter int DEPTH = gcm_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire gcm_pkg::cmd_type push_cmd,
   output logic                  full,
   input  wire logic             pop,
   output gcm_pkg::cmd_type      head,
   output logic                  empty
);
   import gcm_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic               do_push;
   logic               do_pop;

   assign full    = (fill_ff == CNT_W'(DEPTH));
   assign empty   = (fill_ff == '0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

// ===== sv/gcm_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gcm_back
// digit-serial gf(2^128) multiply by h, section counters, tag and compare
// ----------------------------------------------------------------------------
module gcm_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [gcm_pkg::BLOCK_W-1:0]   hash_key,
   input  wire logic [gcm_pkg::BLOCK_W-1:0]   tag_mask,
   input  wire gcm_pkg::cmd_type              head,
   input  wire logic                          empty,
   output logic                               pop,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [gcm_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import gcm_pkg::*;

   function automatic logic [BLOCK_W-1:0] mul_alpha(input logic [BLOCK_W-1:0] v);
      logic [BLOCK_W-1:0] r;
      r = {1'b0, v[BLOCK_W-1:1]};
      if (v[0]) begin
         r[BLOCK_W-1 -: 8] = r[BLOCK_W-1 -: 8] ^ REDUCE_BYTE;
      end
      return r;
   endfunction

   logic [BLOCK_W-1:0]     hash_ff, hash_in;
   logic [BLOCK_W-1:0]     x_ff, x_in;
   logic [BLOCK_W-1:0]     z_ff, z_in;
   logic [BLOCK_W-1:0]     rcv_ff, rcv_in;
   logic [LEN_W-1:0]       aad_ff, aad_in;
   logic [LEN_W-1:0]       text_ff, text_in;
   logic [DIGIT_CNT_W-1:0] digit_ff, digit_in;
   logic                   busy_ff, busy_in;
   logic                   fin_ff, fin_in;
   logic                   out_valid_ff, out_valid_in;
   logic [BLOCK_W-1:0]     out_tag_ff, out_tag_in;
   logic                   out_match_ff, out_match_in;

   logic [BLOCK_W-1:0]     key_pow [DIGIT_W];
   logic [BLOCK_W-1:0]     z_shift;
   logic [BLOCK_W-1:0]     z_next;
   logic [BLOCK_W-1:0]     hash_next;
   logic [BLOCK_W-1:0]     tag;
   logic                   last;
   logic                   out_free;
   logic                   stall;
   logic                   done;

   // h times alpha^j for every bit of a digit
   always_comb begin
      key_pow[0] = hash_key;
      for (int j = 1; j < DIGIT_W; j++) begin
         key_pow[j] = mul_alpha(key_pow[j-1]);
      end
   end

   // horner step: z * alpha^digit plus this digit times h
   always_comb begin
      z_shift = z_ff;
      for (int j = 0; j < DIGIT_W; j++) begin
         z_shift = mul_alpha(z_shift);
      end
      z_next = z_shift;
      for (int j = 0; j < DIGIT_W; j++) begin
         if (x_ff[DIGIT_W-1-j]) begin
            z_next = z_next ^ key_pow[j];
         end
      end
   end

   always_comb begin
      out_free  = !out_valid_ff || rsp_tready;
      last      = busy_ff && (digit_ff == DIGIT_CNT_W'(DIGITS - 1));
      stall     = last && fin_ff && !out_free;
      done      = last && !stall;
      tag       = z_next ^ tag_mask;
      hash_next = done ? (fin_ff ? '0 : z_next) : hash_ff;
      pop       = (!busy_ff || done) && !empty;

      hash_in      = hash_next;
      x_in         = x_ff;
      z_in         = z_ff;
      rcv_in       = rcv_ff;
      aad_in       = aad_ff;
      text_in      = text_ff;
      digit_in     = digit_ff;
      busy_in      = busy_ff;
      fin_in       = fin_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_tag_in   = out_tag_ff;
      out_match_in = out_match_ff;

      if (busy_ff && !stall) begin
         x_in     = {{DIGIT_W{1'b0}}, x_ff[BLOCK_W-1:DIGIT_W]};
         z_in     = z_next;
         digit_in = digit_ff + 1'b1;
         if (done) begin
            busy_in = 1'b0;
         end
      end

      if (done && fin_ff) begin
         out_valid_in = 1'b1;
         out_tag_in   = tag;
         out_match_in = (tag == rcv_ff);
      end

      if (pop) begin
         busy_in  = 1'b1;
         digit_in = '0;
         z_in     = '0;
         rcv_in   = head.blk;
         fin_in   = (head.kind == CMD_FINISH);
         case (head.kind)
            CMD_AAD: begin
               x_in   = hash_next ^ head.blk;
               aad_in = aad_ff + LEN_W'(head.count);
            end
            CMD_TEXT: begin
               x_in    = hash_next ^ head.blk;
               text_in = text_ff + LEN_W'(head.count);
            end
            CMD_FINISH: begin
               x_in    = hash_next ^ {aad_ff, 3'b000, text_ff, 3'b000};
               aad_in  = '0;
               text_in = '0;
            end
            default: begin
               x_in = hash_next ^ head.blk;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff      <= '0;
         aad_ff       <= '0;
         text_ff      <= '0;
         digit_ff     <= '0;
         busy_ff      <= 1'b0;
         fin_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         hash_ff      <= hash_in;
         aad_ff       <= aad_in;
         text_ff      <= text_in;
         digit_ff     <= digit_in;
         busy_ff      <= busy_in;
         fin_ff       <= fin_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff         <= x_in;
      z_ff         <= z_in;
      rcv_ff       <= rcv_in;
      out_tag_ff   <= out_tag_in;
      out_match_ff <= out_match_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'b0000000, out_match_ff,
                        out_tag_ff[HALF_W-1:0], out_tag_ff[BLOCK_W-1:HALF_W]};

endmodule
`default_nettype wire

// ===== sv/gcm_ghash_tag_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// gcm_ghash_tag_engine
// ghash over gf(2^128) with length block and tag masking
// ----------------------------------------------------------------------------
// usage:
//   csr channel writes the hash key h and the encrypted pre-counter block,
//   64 bits at a time, while the engine is idle (csr_ready is always high).
//   req channel: tuser is the op (additional data, ciphertext, finish),
//   tdata carries the block halves and the byte count. short blocks are
//   zero padded, empty data items and the unused op are dropped.
//   rsp channel: one item per finish, the tag and the match flag.
// multiplier: a 32-bit digit loop, one digit of the block times h per cycle
//   while no finish waits on a full rsp register; the next item is popped
//   as the last digit of the one before completes. a finish item goes via
//   the queue, the digit loop and the rsp register, after blocks ahead.
// reset: hash, byte counters, queue and keys clear; rsp_tvalid drops.
// stall: the rsp register holds its item until taken; the queue keeps
//   accepting items meanwhile and req_tready falls only when it is full.
// ----------------------------------------------------------------------------
module gcm_ghash_tag_engine #(
   parameter int QUEUE_DEPTH = gcm_pkg::QUEUE_DEPTH
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // tdata: block_hi[63:0], block_lo[127:64], byte_count[132:128]
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [gcm_pkg::REQ_DATA_W-1:0]  req_tdata,
   // tuser: op[1:0]
   input  wire logic [gcm_pkg::OP_W-1:0]        req_tuser,
   // tdata: tag_hi[63:0], tag_lo[127:64], tag_match[128]
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [gcm_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [gcm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [gcm_pkg::HALF_W-1:0]      csr_data
);
   import gcm_pkg::*;

   logic [HALF_W-1:0] key_hi_ff, key_hi_in;
   logic [HALF_W-1:0] key_lo_ff, key_lo_in;
   logic [HALF_W-1:0] mask_hi_ff, mask_hi_in;
   logic [HALF_W-1:0] mask_lo_ff, mask_lo_in;

   cmd_type           front_cmd;
   cmd_type           head;
   logic              push;
   logic              q_full;
   logic              q_empty;
   logic              pop;

   assign csr_ready = 1'b1;

   always_comb begin
      key_hi_in  = key_hi_ff;
      key_lo_in  = key_lo_ff;
      mask_hi_in = mask_hi_ff;
      mask_lo_in = mask_lo_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_KEY_HI:  key_hi_in  = csr_data;
            CSR_KEY_LO:  key_lo_in  = csr_data;
            CSR_MASK_HI: mask_hi_in = csr_data;
            CSR_MASK_LO: mask_lo_in = csr_data;
            default: begin
               key_hi_in = key_hi_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_hi_ff  <= '0;
         key_lo_ff  <= '0;
         mask_hi_ff <= '0;
         mask_lo_ff <= '0;
      end else begin
         key_hi_ff  <= key_hi_in;
         key_lo_ff  <= key_lo_in;
         mask_hi_ff <= mask_hi_in;
         mask_lo_ff <= mask_lo_in;
      end
   end

   gcm_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .push       (push),
      .cmd        (front_cmd)
   );

   gcm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (front_cmd),
      .full     (q_full),
      .pop      (pop),
      .head     (head),
      .empty    (q_empty)
   );

   gcm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .hash_key   ({key_hi_ff, key_lo_ff}),
      .tag_mask   ({mask_hi_ff, mask_lo_ff}),
      .head       (head),
      .empty      (q_empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire
